// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked every clock outside reset.
`define FAC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define FAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared constants, codes and types of the fully associative cache.
// ----------------------------------------------------------------------------
package fac_pkg;

    localparam int LINE_BYTES = 64;
    localparam int ENTRIES    = 16;
    localparam int CPU_PORTS  = 4;
    localparam int ADDR_BITS  = 32;

    localparam int BEATS      = LINE_BYTES / 8;
    localparam int OFF_BITS   = $clog2(LINE_BYTES);
    localparam int BEAT_BITS  = $clog2(BEATS);
    localparam int SLOT_BITS  = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int TAG_BITS   = ADDR_BITS - OFF_BITS;
    localparam int RAM_DEPTH  = ENTRIES * BEATS;
    localparam int RAM_AW     = SLOT_BITS + BEAT_BITS;
    localparam int LFSR_BITS  = 16;
    localparam int DIV_CNT_BITS = $clog2(LFSR_BITS);
    localparam int QDEPTH     = 2;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int PADDR_BITS = 3;

    localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [4:0]           CAPACITY_RESET = 5'd16;
    localparam logic [15:0]          SEED_RESET = 16'd1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_BAD   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_RDATA = 3'd0,
        KIND_WACK  = 3'd1,
        KIND_LREQ  = 3'd2,
        KIND_WB    = 3'd3,
        KIND_BUSY  = 3'd4,
        KIND_ERR   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        CLS_ACCESS,
        CLS_FILL,
        CLS_BADCMD
    } cls_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_SEED     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        cls_t                 cls;
        logic                 is_write;
        logic                 bad;
        logic [1:0]           port;
        logic [ADDR_BITS-1:0] addr;
        logic [3:0]           nbytes;
        logic [63:0]          wdata;
        logic [63:0]          fdata;
    } item_t;

    typedef struct packed {
        logic [4:0]  capacity;
        logic        seed_load;
        logic [15:0] seed;
    } cfg_t;

endpackage

// ===== rtl/core/fac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fac_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fac_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fac_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fac_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [1:0]                    s_port_in,
    input  logic [fac_pkg::ADDR_BITS-1:0] s_access_addr,
    input  logic [3:0]                    s_access_bytes,
    input  logic [63:0]                   s_write_data,
    input  logic [63:0]                   s_fill_data,
    output fac_pkg::item_t                head,
    output logic                          head_valid,
    input  logic                          pop
);

    fac_pkg::item_t                 item_in;
    fac_pkg::item_t                 q_reg [fac_pkg::QDEPTH];
    logic [fac_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [fac_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [fac_pkg::QPTR_BITS:0]    count_reg;
    logic                           push;
    logic [fac_pkg::OFF_BITS:0]     end_byte;
    logic                           span_bad;
    logic                           port_bad;

    // end offset of the access, one past its last byte
    assign end_byte = (fac_pkg::OFF_BITS+1)'(s_access_addr[fac_pkg::OFF_BITS-1:0])
                    + (fac_pkg::OFF_BITS+1)'(s_access_bytes);
    assign span_bad = end_byte > (fac_pkg::OFF_BITS+1)'(fac_pkg::LINE_BYTES);
    assign port_bad = {1'b0, s_port_in} >= 3'(fac_pkg::CPU_PORTS);

    always_comb begin
        item_in.is_write = 1'b0;
        unique case (fac_pkg::cmd_t'(s_cmd))
            fac_pkg::CMD_READ:  item_in.cls = fac_pkg::CLS_ACCESS;
            fac_pkg::CMD_WRITE: begin
                item_in.cls      = fac_pkg::CLS_ACCESS;
                item_in.is_write = 1'b1;
            end
            fac_pkg::CMD_FILL:  item_in.cls = fac_pkg::CLS_FILL;
            fac_pkg::CMD_BAD:   item_in.cls = fac_pkg::CLS_BADCMD;
            default:            item_in.cls = fac_pkg::CLS_BADCMD;
        endcase
        item_in.bad    = (s_access_bytes == 4'd0) || (s_access_bytes > 4'd8)
                       || span_bad || port_bad;
        item_in.port   = s_port_in;
        item_in.addr   = s_access_addr;
        item_in.nbytes = s_access_bytes;
        item_in.wdata  = s_write_data;
        item_in.fdata  = s_fill_data;
    end

    assign s_ready    = count_reg != (fac_pkg::QPTR_BITS+1)'(fac_pkg::QDEPTH);
    assign push       = s_valid && s_ready;
    assign head_valid = count_reg != '0;
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= item_in;
                wr_ptr_reg        <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `FAC_ASSERT(a_q_bound, aclk, aresetn, count_reg <= (fac_pkg::QPTR_BITS+1)'(fac_pkg::QDEPTH), "queue overfilled")
    `FAC_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")
    `FAC_ASSERT_NXT(a_push_count, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/core/fac_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fac_back
// Lookup, line store, miss/fill handling, eviction and the result register.
// ----------------------------------------------------------------------------
module fac_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fac_pkg::item_t                head,
    input  logic                          head_valid,
    output logic                          pop,
    input  fac_pkg::cfg_t                 cfg,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_result_kind,
    output logic [1:0]                    m_port_out,
    output logic [fac_pkg::ADDR_BITS-1:0] m_out_addr,
    output logic [63:0]                   m_out_data,
    output logic                          m_was_hit,
    output logic                          m_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_MERGE, S_WR1, S_RESP,
        S_EVCHK, S_DIV, S_FIND, S_WB_RD, S_WB_EMIT, S_FILL
    } state_t;

    localparam int OB = fac_pkg::OFF_BITS;
    localparam int BB = fac_pkg::BEAT_BITS;
    localparam int SB = fac_pkg::SLOT_BITS;
    localparam int CB = fac_pkg::CNT_BITS;
    localparam int LB = fac_pkg::LFSR_BITS;

    state_t                          state_reg;
    logic [fac_pkg::ENTRIES-1:0]     valid_reg;
    logic [fac_pkg::TAG_BITS-1:0]    tag_reg [fac_pkg::ENTRIES];
    logic [CB-1:0]                   used_reg;
    logic                            miss_reg;
    logic [1:0]                      pend_port_reg;
    logic [fac_pkg::ADDR_BITS-1:0]   pend_addr_reg;
    logic [3:0]                      pend_n_reg;
    logic                            pend_write_reg;
    logic [63:0]                     pend_wdata_reg;
    logic [63:0]                     fillbuf_reg [fac_pkg::BEATS];
    logic [BB-1:0]                   fill_beat_reg;
    logic [LB-1:0]                   lfsr_reg;

    logic [SB-1:0]                   acc_slot_reg;
    logic [OB-1:0]                   acc_off_reg;
    logic [3:0]                      acc_n_reg;
    logic                            acc_write_reg;
    logic [63:0]                     acc_wdata_reg;
    logic [1:0]                      acc_port_reg;
    logic [fac_pkg::ADDR_BITS-1:0]   acc_addr_reg;
    logic                            acc_hit_reg;
    logic [63:0]                     lo_reg;
    logic [63:0]                     hi_reg;
    logic [BB-1:0]                   beat_reg;
    logic [CB-1:0]                   rem_reg;
    logic [LB-1:0]                   divq_reg;
    logic [fac_pkg::DIV_CNT_BITS-1:0] divcnt_reg;
    logic [SB-1:0]                   scan_idx_reg;
    logic [CB-1:0]                   scan_cnt_reg;

    logic                            m_valid_reg;
    logic [2:0]                      m_kind_reg;
    logic [1:0]                      m_port_reg;
    logic [fac_pkg::ADDR_BITS-1:0]   m_addr_reg;
    logic [63:0]                     m_data_reg;
    logic                            m_hit_reg;
    logic                            m_last_reg;

    logic                            can_emit;
    logic                            emit;
    logic [fac_pkg::ENTRIES-1:0]     hit_vec;
    logic [SB-1:0]                   hit_slot;
    logic [SB-1:0]                   free_slot;
    logic [CB-1:0]                   eff_cap;
    logic [LB-1:0]                   lfsr_step;
    logic [CB:0]                     div_trial;
    logic [CB-1:0]                   rem_next;
    logic [BB-1:0]                   widx;
    logic [BB-1:0]                   widx1;
    logic                            span;
    logic [5:0]                      sh8;
    logic [63:0]                     bmask;
    logic [127:0]                    window;
    logic [127:0]                    merged;
    logic [63:0]                     rd_bytes;
    logic                            ram_we;
    logic [fac_pkg::RAM_AW-1:0]      ram_waddr;
    logic [63:0]                     ram_wdata;
    logic                            ram_re;
    logic [fac_pkg::RAM_AW-1:0]      ram_raddr;
    logic [63:0]                     ram_rdata;

    fac_ram #(
        .WIDTH (64),
        .DEPTH (fac_pkg::RAM_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign can_emit = !m_valid_reg || m_ready;

    // parallel tag match, lowest slot wins
    always_comb begin
        hit_slot  = '0;
        free_slot = '0;
        for (int i = fac_pkg::ENTRIES - 1; i >= 0; i--) begin
            hit_vec[i] = valid_reg[i]
                      && (tag_reg[i] == head.addr[fac_pkg::ADDR_BITS-1:OB]);
            if (hit_vec[i]) begin
                hit_slot = SB'(i);
            end
            if (!valid_reg[i]) begin
                free_slot = SB'(i);
            end
        end
    end

    // a result word is loaded this cycle
    assign emit = (pop && (head.cls != fac_pkg::CLS_FILL)
                   && !((head.cls != fac_pkg::CLS_BADCMD) && !miss_reg && !head.bad
                        && (hit_vec != '0)))
               || (((state_reg == S_RESP) || (state_reg == S_WB_EMIT)) && can_emit);

    always_comb begin
        if (cfg.capacity == 5'd0) begin
            eff_cap = CB'(1);
        end else if (cfg.capacity > 5'(fac_pkg::ENTRIES)) begin
            eff_cap = CB'(fac_pkg::ENTRIES);
        end else begin
            eff_cap = CB'(cfg.capacity);
        end
    end

    assign lfsr_step = {1'b0, lfsr_reg[LB-1:1]} ^ (lfsr_reg[0] ? fac_pkg::LFSR_TAPS : '0);

    // one restoring step of lfsr mod used_reg per cycle
    assign div_trial = {rem_reg, divq_reg[LB-1]};
    assign rem_next  = (div_trial >= {1'b0, used_reg}) ? CB'(div_trial - {1'b0, used_reg})
                                                       : div_trial[CB-1:0];

    assign widx  = acc_off_reg[OB-1:3];
    assign widx1 = widx + 1'b1;
    assign span  = ({1'b0, acc_off_reg[2:0]} + acc_n_reg) > 4'd8;
    assign sh8   = {acc_off_reg[2:0], 3'b000};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            bmask[i*8 +: 8] = (4'(i) < acc_n_reg) ? 8'hFF : 8'h00;
        end
        window   = {hi_reg, lo_reg};
        merged   = (window & ~({64'd0, bmask} << sh8))
                 | ({64'd0, acc_wdata_reg & bmask} << sh8);
        rd_bytes = 64'(window >> sh8) & bmask;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {acc_slot_reg, widx};
        ram_wdata = merged[63:0];
        ram_re    = 1'b0;
        ram_raddr = {acc_slot_reg, widx};
        unique case (state_reg)
            S_RD0:     ram_re = 1'b1;
            S_RD1: begin
                ram_re    = span;
                ram_raddr = {acc_slot_reg, widx1};
            end
            S_MERGE:   ram_we = acc_write_reg;
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = {acc_slot_reg, widx1};
                ram_wdata = merged[127:64];
            end
            S_WB_RD: begin
                ram_re    = 1'b1;
                ram_raddr = {acc_slot_reg, beat_reg};
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = {acc_slot_reg, beat_reg};
                ram_wdata = fillbuf_reg[beat_reg];
            end
            default: ;
        endcase
    end

    assign pop = (state_reg == S_IDLE) && head_valid
              && ((head.cls == fac_pkg::CLS_FILL) || can_emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            used_reg      <= '0;
            miss_reg      <= 1'b0;
            fill_beat_reg <= '0;
            lfsr_reg      <= LB'(fac_pkg::SEED_RESET);
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        unique case (head.cls)
                            fac_pkg::CLS_BADCMD: begin
                                m_valid_reg <= 1'b1;
                                m_kind_reg  <= fac_pkg::KIND_ERR;
                                m_port_reg  <= head.port;
                                m_addr_reg  <= head.addr;
                                m_data_reg  <= '0;
                                m_hit_reg   <= 1'b0;
                                m_last_reg  <= 1'b1;
                            end
                            fac_pkg::CLS_FILL: begin
                                if (miss_reg) begin
                                    fillbuf_reg[fill_beat_reg] <= head.fdata;
                                    if (fill_beat_reg == BB'(fac_pkg::BEATS - 1)) begin
                                        state_reg <= S_EVCHK;
                                    end else begin
                                        fill_beat_reg <= fill_beat_reg + 1'b1;
                                    end
                                end
                            end
                            default: begin
                                priority if (miss_reg || head.bad) begin
                                    m_valid_reg <= 1'b1;
                                    m_kind_reg  <= miss_reg ? fac_pkg::KIND_BUSY
                                                            : fac_pkg::KIND_ERR;
                                    m_port_reg  <= head.port;
                                    m_addr_reg  <= head.addr;
                                    m_data_reg  <= '0;
                                    m_hit_reg   <= 1'b0;
                                    m_last_reg  <= 1'b1;
                                end else if (hit_vec != '0) begin
                                    acc_slot_reg  <= hit_slot;
                                    acc_off_reg   <= head.addr[OB-1:0];
                                    acc_n_reg     <= head.nbytes;
                                    acc_write_reg <= head.is_write;
                                    acc_wdata_reg <= head.wdata;
                                    acc_port_reg  <= head.port;
                                    acc_addr_reg  <= head.addr;
                                    acc_hit_reg   <= 1'b1;
                                    state_reg     <= S_RD0;
                                end else begin
                                    miss_reg       <= 1'b1;
                                    pend_port_reg  <= head.port;
                                    pend_addr_reg  <= head.addr;
                                    pend_n_reg     <= head.nbytes;
                                    pend_write_reg <= head.is_write;
                                    pend_wdata_reg <= head.wdata;
                                    fill_beat_reg  <= '0;
                                    m_valid_reg    <= 1'b1;
                                    m_kind_reg     <= fac_pkg::KIND_LREQ;
                                    m_port_reg     <= '0;
                                    m_addr_reg     <= {head.addr[fac_pkg::ADDR_BITS-1:OB],
                                                       OB'(0)};
                                    m_data_reg     <= '0;
                                    m_hit_reg      <= 1'b0;
                                    m_last_reg     <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1: begin
                    lo_reg <= ram_rdata;
                    if (span) begin
                        state_reg <= S_RD2;
                    end else begin
                        hi_reg    <= '0;
                        state_reg <= S_MERGE;
                    end
                end
                S_RD2: begin
                    hi_reg    <= ram_rdata;
                    state_reg <= S_MERGE;
                end
                S_MERGE: state_reg <= (acc_write_reg && span) ? S_WR1 : S_RESP;
                S_WR1:   state_reg <= S_RESP;
                S_RESP: begin
                    if (can_emit) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= acc_write_reg ? fac_pkg::KIND_WACK
                                                     : fac_pkg::KIND_RDATA;
                        m_port_reg  <= acc_port_reg;
                        m_addr_reg  <= acc_addr_reg;
                        m_data_reg  <= acc_write_reg ? 64'd0 : rd_bytes;
                        m_hit_reg   <= acc_hit_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_EVCHK: begin
                    beat_reg <= '0;
                    if ((used_reg >= eff_cap) && (used_reg != '0)) begin
                        lfsr_reg   <= lfsr_step;
                        divq_reg   <= lfsr_step;
                        rem_reg    <= '0;
                        divcnt_reg <= '1;
                        state_reg  <= S_DIV;
                    end else begin
                        acc_slot_reg <= free_slot;
                        state_reg    <= S_FILL;
                    end
                end
                S_DIV: begin
                    rem_reg  <= rem_next;
                    divq_reg <= {divq_reg[LB-2:0], 1'b0};
                    if (divcnt_reg == '0) begin
                        scan_idx_reg <= '0;
                        scan_cnt_reg <= '0;
                        state_reg    <= S_FIND;
                    end else begin
                        divcnt_reg <= divcnt_reg - 1'b1;
                    end
                end
                S_FIND: begin
                    // walk valid slots until the picked one is reached
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (valid_reg[scan_idx_reg]) begin
                        if (scan_cnt_reg == rem_reg) begin
                            acc_slot_reg <= scan_idx_reg;
                            state_reg    <= S_WB_RD;
                        end else begin
                            scan_cnt_reg <= scan_cnt_reg + 1'b1;
                        end
                    end
                end
                S_WB_RD: state_reg <= S_WB_EMIT;
                S_WB_EMIT: begin
                    if (can_emit) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= fac_pkg::KIND_WB;
                        m_port_reg  <= '0;
                        m_addr_reg  <= {tag_reg[acc_slot_reg], OB'(0)};
                        m_data_reg  <= ram_rdata;
                        m_hit_reg   <= 1'b0;
                        m_last_reg  <= 1'b0;
                        if (beat_reg == BB'(fac_pkg::BEATS - 1)) begin
                            valid_reg[acc_slot_reg] <= 1'b0;
                            used_reg                <= used_reg - 1'b1;
                            beat_reg                <= '0;
                            state_reg               <= S_FILL;
                        end else begin
                            beat_reg  <= beat_reg + 1'b1;
                            state_reg <= S_WB_RD;
                        end
                    end
                end
                S_FILL: begin
                    if (beat_reg == BB'(fac_pkg::BEATS - 1)) begin
                        tag_reg[acc_slot_reg]   <= pend_addr_reg[fac_pkg::ADDR_BITS-1:OB];
                        valid_reg[acc_slot_reg] <= 1'b1;
                        used_reg                <= used_reg + 1'b1;
                        acc_off_reg             <= pend_addr_reg[OB-1:0];
                        acc_n_reg               <= pend_n_reg;
                        acc_write_reg           <= pend_write_reg;
                        acc_wdata_reg           <= pend_wdata_reg;
                        acc_port_reg            <= pend_port_reg;
                        acc_addr_reg            <= pend_addr_reg;
                        acc_hit_reg             <= 1'b0;
                        miss_reg                <= 1'b0;
                        fill_beat_reg           <= '0;
                        state_reg               <= S_RD0;
                    end else begin
                        beat_reg <= beat_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg.seed_load) begin
                lfsr_reg <= (cfg.seed == 16'd0) ? LB'(1) : cfg.seed;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_port_out    = m_port_reg;
    assign m_out_addr    = m_addr_reg;
    assign m_out_data    = m_data_reg;
    assign m_was_hit     = m_hit_reg;
    assign m_last        = m_last_reg;

    `FAC_ASSERT(a_used_count, aclk, aresetn, $countones(valid_reg) == 32'(used_reg), "lines_used out of step with valid bits")
    `FAC_ASSERT_IMP(a_beat_needs_miss, aclk, aresetn, fill_beat_reg != '0, miss_reg, "fill beats counted without a miss")
    `FAC_ASSERT_IMP(a_emit_room, aclk, aresetn, (state_reg == S_WB_EMIT) && m_valid_reg && !m_ready, 1'b1 && !can_emit, "result register overwritten")

endmodule

// ===== rtl/core/blocking_fully_assoc_writeback_cache.sv =====
`timescale 1ns / 1ps
// A blocking, fully associative, write-allocate cache of 16 lines of 64
// bytes. A cpu word that hits goes from acceptance to the response word
// through dequeue, one or two reads of the line store's one read port,
// a second write for a write that straddles two store words and the
// response; a miss answers with a line request, registered when the word
// is dequeued, and then rejects accesses until 8 fill words have arrived.
// Finishing a fill takes a capacity check, the install of the 8 words and
// then the access itself; with eviction a bit-serial victim modulo, a
// victim scan and a writeback of the victim line come before the install.
// ----------------------------------------------------------------------------
// blocking_fully_assoc_writeback_cache
// Top level: APB register file, input queue front end and cache back end.
// ----------------------------------------------------------------------------
module blocking_fully_assoc_writeback_cache (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fac_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [1:0]                      s_port_in,
    input  logic [fac_pkg::ADDR_BITS-1:0]   s_access_addr,
    input  logic [3:0]                      s_access_bytes,
    input  logic [63:0]                     s_write_data,
    input  logic [63:0]                     s_fill_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_result_kind,
    output logic [1:0]                      m_port_out,
    output logic [fac_pkg::ADDR_BITS-1:0]   m_out_addr,
    output logic [63:0]                     m_out_data,
    output logic                            m_was_hit,
    output logic                            m_last
);

    logic [4:0]        capacity_reg;
    logic [15:0]       seed_reg;
    logic              reg_wr;
    fac_pkg::reg_idx_t reg_idx;
    fac_pkg::cfg_t     cfg;
    fac_pkg::item_t    head;
    logic              head_valid;
    logic              pop;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_idx = fac_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= fac_pkg::CAPACITY_RESET;
            seed_reg     <= fac_pkg::SEED_RESET;
        end else if (reg_wr) begin
            unique case (reg_idx)
                fac_pkg::REG_CAPACITY: capacity_reg <= pwdata[4:0];
                fac_pkg::REG_SEED:     seed_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fac_pkg::REG_CAPACITY: prdata = {27'd0, capacity_reg};
            fac_pkg::REG_SEED:     prdata = {16'd0, seed_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.capacity  = capacity_reg;
    assign cfg.seed_load = reg_wr && (reg_idx == fac_pkg::REG_SEED);
    assign cfg.seed      = pwdata[15:0];

    fac_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_port_in      (s_port_in),
        .s_access_addr  (s_access_addr),
        .s_access_bytes (s_access_bytes),
        .s_write_data   (s_write_data),
        .s_fill_data    (s_fill_data),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    fac_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .cfg           (cfg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_port_out    (m_port_out),
        .m_out_addr    (m_out_addr),
        .m_out_data    (m_out_data),
        .m_was_hit     (m_was_hit),
        .m_last        (m_last)
    );

endmodule
